### rtl/hc_pkg.sv
// Package for the 2x2 mod-26 Hill cipher: shared types, constants and
// modular helper functions. No dependencies.
package hc_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned SumW     = 11;
  localparam int unsigned DataW    = 8;
  localparam logic [LetterW-1:0] Modulus   = 5'd26;
  localparam logic [LetterW-1:0] PadLetter = 5'd25;
  localparam logic [2:0] SettleCycles = 3'd5;

  localparam logic [1:0] IdxK00 = 2'd0;
  localparam logic [1:0] IdxK01 = 2'd1;
  localparam logic [1:0] IdxK10 = 2'd2;
  localparam logic [1:0] IdxK11 = 2'd3;

  localparam logic FuncEncrypt = 1'b0;

  typedef struct packed {
    logic [LetterW-1:0] m00;
    logic [LetterW-1:0] m01;
    logic [LetterW-1:0] m10;
    logic [LetterW-1:0] m11;
  } mat_t;

  typedef struct packed {
    mat_t enc;
    mat_t dec;
    logic err;
    logic busy;
  } key_t;

  typedef struct packed {
    logic               func;
    logic [LetterW-1:0] p0;
    logic [LetterW-1:0] p1;
    logic               fin;
  } pair_t;

  // reduce an 11-bit value mod 26: reciprocal estimate, then one correction
  function automatic logic [LetterW-1:0] mod26(input logic [SumW-1:0] v);
    logic [17:0]       prod;
    logic [5:0]        q;
    logic signed [12:0] r;
    prod = {7'd0, v} * 18'd79;
    q    = prod[16:11];
    r    = $signed({2'b00, v}) - $signed({1'b0, 12'(q * 7'd26)});
    if (r < 0) begin
      r = r + 13'sd26;
    end
    return r[LetterW-1:0];
  endfunction

  function automatic logic [LetterW-1:0] reduce_key(input logic [LetterW-1:0] k);
    return (k >= Modulus) ? (k - Modulus) : k;
  endfunction

  function automatic logic [LetterW-1:0] neg_mod26(input logic [LetterW-1:0] k);
    return (k == '0) ? '0 : (Modulus - k);
  endfunction

  // inverse mod 26, zero where none exists
  function automatic logic [LetterW-1:0] inv_mod26(input logic [LetterW-1:0] v);
    logic [LetterW-1:0] r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/hc_keygen.sv
// Key registers and decryption key derivation over five registered stages.
// Depends on hc_pkg.
module hc_keygen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [hc_pkg::LetterW-1:0]  cfg_data_i,
  output hc_pkg::key_t                key_o
);

  logic [hc_pkg::LetterW-1:0] k00_q, k01_q, k10_q, k11_q;
  logic [hc_pkg::LetterW-1:0] a_q, b_q, c_q, d_q;
  logic [9:0]                 ad_q, bc_q;
  logic [hc_pkg::LetterW-1:0] det_q, inv_q;
  logic                       err_q;
  logic [9:0]                 p00_q, p01_q, p10_q, p11_q;
  hc_pkg::mat_t               dec_q;
  logic [2:0]                 cnt_q, cnt_d;
  logic [hc_pkg::LetterW:0]   det_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k00_q <= 5'd1;
      k01_q <= 5'd0;
      k10_q <= 5'd0;
      k11_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hc_pkg::IdxK00: k00_q <= cfg_data_i;
        hc_pkg::IdxK01: k01_q <= cfg_data_i;
        hc_pkg::IdxK10: k10_q <= cfg_data_i;
        hc_pkg::IdxK11: k11_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = hc_pkg::SettleCycles;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= hc_pkg::SettleCycles;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign det_sum = {1'b0, hc_pkg::mod26({1'b0, ad_q})} + 6'd26
                 - {1'b0, hc_pkg::mod26({1'b0, bc_q})};

  always_ff @(posedge clk_i) begin
    a_q   <= hc_pkg::reduce_key(k00_q);
    b_q   <= hc_pkg::reduce_key(k01_q);
    c_q   <= hc_pkg::reduce_key(k10_q);
    d_q   <= hc_pkg::reduce_key(k11_q);
    ad_q  <= 10'(hc_pkg::reduce_key(k00_q) * hc_pkg::reduce_key(k11_q));
    bc_q  <= 10'(hc_pkg::reduce_key(k01_q) * hc_pkg::reduce_key(k10_q));
    det_q <= (det_sum >= 6'd26) ? 5'(det_sum - 6'd26) : det_sum[hc_pkg::LetterW-1:0];
    inv_q <= hc_pkg::inv_mod26(det_q);
    err_q <= (hc_pkg::inv_mod26(det_q) == '0);
    p00_q <= 10'(d_q * inv_q);
    p01_q <= 10'(hc_pkg::neg_mod26(b_q) * inv_q);
    p10_q <= 10'(hc_pkg::neg_mod26(c_q) * inv_q);
    p11_q <= 10'(a_q * inv_q);
    dec_q.m00 <= hc_pkg::mod26({1'b0, p00_q});
    dec_q.m01 <= hc_pkg::mod26({1'b0, p01_q});
    dec_q.m10 <= hc_pkg::mod26({1'b0, p10_q});
    dec_q.m11 <= hc_pkg::mod26({1'b0, p11_q});
  end

  assign key_o.enc.m00 = a_q;
  assign key_o.enc.m01 = b_q;
  assign key_o.enc.m10 = c_q;
  assign key_o.enc.m11 = d_q;
  assign key_o.dec     = dec_q;
  assign key_o.err     = err_q;
  assign key_o.busy    = (cnt_q != '0);

endmodule

### rtl/hc_front.sv
// Input side: accepts letters, pairs them, pads a lone final letter.
// Depends on hc_pkg.
module hc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        func_i,
  input  logic [hc_pkg::LetterW-1:0]  letter_i,
  input  logic                        fin_i,
  input  logic                        q_full_i,
  input  logic                        key_busy_i,
  output logic                        in_ready_o,
  output logic                        push_o,
  output hc_pkg::pair_t               push_data_o
);

  logic                       held_valid_q, held_valid_d;
  logic [hc_pkg::LetterW-1:0] held_q, held_d;
  logic                       acc;

  assign in_ready_o = !q_full_i && !key_busy_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    held_valid_d     = held_valid_q;
    held_d           = held_q;
    push_o           = 1'b0;
    push_data_o.func = func_i;
    push_data_o.fin  = fin_i;
    push_data_o.p0   = held_valid_q ? held_q : letter_i;
    push_data_o.p1   = held_valid_q ? letter_i : hc_pkg::PadLetter;
    if (acc) begin
      if (!held_valid_q && !fin_i) begin
        held_valid_d = 1'b1;
        held_d       = letter_i;
      end else begin
        push_o       = 1'b1;
        held_valid_d = 1'b0;
        held_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
    end
  end

endmodule

### rtl/hc_fifo.sv
// Two-entry queue of letter pairs between the front and back ends.
// Depends on hc_pkg.
module hc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hc_pkg::pair_t  push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output hc_pkg::pair_t  rdata_o
);

  hc_pkg::pair_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/hc_back.sv
// Output side: pair times matrix mod 26, then two letters out in order.
// Depends on hc_pkg.
module hc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hc_pkg::key_t                key_i,
  input  logic                        q_empty_i,
  input  hc_pkg::pair_t               q_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hc_pkg::LetterW-1:0]  letter_o,
  output logic                        last_o,
  output logic                        err_o
);

  logic                       v1_q;
  logic [hc_pkg::SumW-1:0]    s0_q, s1_q;
  logic                       fin1_q, err1_q;
  logic [1:0]                 pend_q;
  logic [hc_pkg::LetterW-1:0] out_q, second_q;
  logic                       fin2_q, err2_q;
  logic                       out_acc, load2, adv1;
  hc_pkg::mat_t               m;

  assign out_acc = out_valid_o && out_ready_i;
  assign load2   = (pend_q == 2'd0) || ((pend_q == 2'd1) && out_ready_i);
  assign adv1    = v1_q && load2;
  assign pop_o   = !q_empty_i && (!v1_q || adv1);
  assign m       = (q_data_i.func == hc_pkg::FuncEncrypt) ? key_i.enc : key_i.dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      pend_q <= 2'd0;
    end else begin
      if (pop_o) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        pend_q <= 2'd2;
      end else if (out_acc) begin
        pend_q <= pend_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s0_q   <= 11'(m.m00 * q_data_i.p0) + 11'(m.m01 * q_data_i.p1);
      s1_q   <= 11'(m.m10 * q_data_i.p0) + 11'(m.m11 * q_data_i.p1);
      fin1_q <= q_data_i.fin;
      err1_q <= key_i.err;
    end
    if (adv1) begin
      out_q    <= hc_pkg::mod26(s0_q);
      second_q <= hc_pkg::mod26(s1_q);
      fin2_q   <= fin1_q;
      err2_q   <= err1_q;
    end else if (out_acc && (pend_q == 2'd2)) begin
      out_q <= second_q;
    end
  end

  assign out_valid_o = (pend_q != 2'd0);
  assign letter_o    = out_q;
  assign last_o      = fin2_q && (pend_q == 2'd1);
  assign err_o       = err2_q;

endmodule

### rtl/hill_cipher_2x2.sv
// 2x2 Hill cipher mod 26: a letter per input request, two letters per pair.
// A completed pair is queued, summed into registers, then reduced to two letters.
// A new pair is loaded only as the previous pair's last letter is taken.
// After reset or a key write, input is held off while the key settles.
// Reset (rst_ni, async low) loads the identity key and drops any held letter.
module hill_cipher_2x2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [hc_pkg::DataW-1:0]   s_axis_tdata,   // [4:0] letter_in, [7:5] zero
  input  logic                       s_axis_tuser,   // [0] func
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [hc_pkg::DataW-1:0]   m_axis_tdata,   // [4:0] letter_out, [7:5] zero
  output logic                       m_axis_tuser,   // [0] key_error
  output logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [hc_pkg::LetterW-1:0] cfg_data_i
);

  hc_pkg::key_t               key;
  hc_pkg::pair_t              push_data, q_data;
  logic                       push, pop, q_full, q_empty;
  logic [hc_pkg::LetterW-1:0] letter_out;

  hc_keygen u_keygen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key)
  );

  hc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .func_i      (s_axis_tuser),
    .letter_i    (s_axis_tdata[hc_pkg::LetterW-1:0]),
    .fin_i       (s_axis_tlast),
    .q_full_i    (q_full),
    .key_busy_i  (key.busy),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .rdata_o     (q_data)
  );

  hc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .letter_o    (letter_out),
    .last_o      (m_axis_tlast),
    .err_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, letter_out};

endmodule

### rtl/hc_checker.sv
// Port-level checks for hill_cipher_2x2, bound to the top level.
// Depends on hc_pkg.
module hc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [hc_pkg::DataW-1:0]   m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast,
  input logic                       cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata < 8'd26)
    else $error("output letter out of range");

  a_key_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while key settles");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !(m_axis_tvalid && m_axis_tlast))
    else $error("two last letters in a row");

endmodule

bind hill_cipher_2x2 hc_checker u_hc_checker (.*);
